// ===== rtl/slc_pkg.sv =====
// shared types, codes and defaults of the sprite layer compositor
`default_nettype none
package slc_pkg;

  // default sizes
  localparam int MAX_LAYERS_DEF    = 8;
  localparam int STICKER_MAX_W_DEF = 64;
  localparam int STICKER_MAX_H_DEF = 64;

  // command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_MOVE   = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_RENDER = 3'd4;
  localparam logic [2:0] CMD_SIZE   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LAYERS = 2'd0;
  localparam logic [1:0] REG_BASE_W = 2'd1;
  localparam logic [1:0] REG_BASE_H = 2'd2;
  localparam logic [1:0] REG_BG     = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [6:0]  sticker_width;
    logic [6:0]  sticker_height;
    logic [31:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_out;
    logic [31:0] pixel_out;
    logic [13:0] canvas_width;
    logic [13:0] canvas_height;
  } out_word_t;

  // command class decided by the front end
  typedef enum logic [2:0] {
    K_ADD, K_WRITE, K_MOVE, K_REMOVE, K_RENDER, K_SIZE, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_word_t item;
  } q_entry_t;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

endpackage
`default_nettype wire

// ===== rtl/slc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module slc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/slc_front.sv =====
// front end: command classification and a two word queue
`default_nettype none
module slc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire slc_pkg::in_word_t in_word,
  output logic                   q_valid,
  output slc_pkg::q_entry_t      q_entry,
  input  wire logic              q_pop
);
  import slc_pkg::*;

  q_entry_t   buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  kind_t      kind;

  // classify the incoming command
  always_comb begin
    unique case (in_word.cmd)
      CMD_ADD:    kind = K_ADD;
      CMD_WRITE:  kind = K_WRITE;
      CMD_MOVE:   kind = K_MOVE;
      CMD_REMOVE: kind = K_REMOVE;
      CMD_RENDER: kind = K_RENDER;
      CMD_SIZE:   kind = K_SIZE;
      default:    kind = K_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_entry  = buf_q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= '{kind: kind, item: in_word};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, q_pop});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/slc_back.sv =====
// back end: slot table, sticker memory and command sequencer
`default_nettype none
module slc_back #(
  parameter int MAX_LAYERS    = slc_pkg::MAX_LAYERS_DEF,
  parameter int STICKER_MAX_W = slc_pkg::STICKER_MAX_W_DEF,
  parameter int STICKER_MAX_H = slc_pkg::STICKER_MAX_H_DEF,
  parameter int LW            = $clog2(MAX_LAYERS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire slc_pkg::q_entry_t  q_entry,
  output logic                    q_pop,
  input  wire logic [LW-1:0]      limit,
  input  wire logic [12:0]        base_w,
  input  wire logic [12:0]        base_h,
  input  wire logic [31:0]        bg_pixel,
  input  wire logic               clr_en,
  input  wire logic [LW-1:0]      clr_from,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output slc_pkg::out_word_t      out_word
);
  import slc_pkg::*;

  localparam int SW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int WW    = $clog2(STICKER_MAX_W + 1);
  localparam int HW    = $clog2(STICKER_MAX_H + 1);
  localparam int XW    = (STICKER_MAX_W > 1) ? $clog2(STICKER_MAX_W) : 1;
  localparam int YW    = (STICKER_MAX_H > 1) ? $clog2(STICKER_MAX_H) : 1;
  localparam int DEPTH = MAX_LAYERS * STICKER_MAX_W * STICKER_MAX_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (LW > 3) ? LW : 3;
  localparam int DW    = (WW > 7) ? WW : 7;
  localparam int EW    = (HW > 7) ? HW : 7;

  // slot table
  logic          valid [MAX_LAYERS];
  logic [11:0]   t_px  [MAX_LAYERS];
  logic [11:0]   t_py  [MAX_LAYERS];
  logic [WW-1:0] t_w   [MAX_LAYERS];
  logic [HW-1:0] t_h   [MAX_LAYERS];

  state_t        state, state_next;
  q_entry_t      cur;
  logic [LW-1:0] cnt;
  logic [13:0]   cw, ch;

  logic [SW-1:0] idx;
  logic          r_valid;
  logic [11:0]   r_px, r_py;
  logic [WW-1:0] r_w;
  logic [HW-1:0] r_h;
  logic          usable;
  logic          covers;
  logic [11:0]   dx, dy;
  logic [13:0]   right, bottom;
  logic [WW-1:0] add_w;
  logic [HW-1:0] add_h;

  logic          finish;
  out_word_t     res;
  logic          tbl_add, tbl_move, tbl_rm, cnt_inc, cnt_dec, size_upd;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;

  // table read port
  always_comb begin
    if (cur.kind == K_RENDER) begin
      idx = SW'(cnt - LW'(1));
    end else if (cur.kind == K_ADD || cur.kind == K_SIZE) begin
      idx = SW'(cnt);
    end else begin
      idx = SW'(cur.item.slot);
    end
  end

  assign r_valid = valid[idx];
  assign r_px    = t_px[idx];
  assign r_py    = t_py[idx];
  assign r_w     = t_w[idx];
  assign r_h     = t_h[idx];

  // slot checks and coverage
  assign usable = (CW'(cur.item.slot) < CW'(limit)) && r_valid;
  assign dx     = cur.item.pos_x - r_px;
  assign dy     = cur.item.pos_y - r_py;
  assign covers = (cur.item.pos_x >= r_px) && (cur.item.pos_y >= r_py)
                  && (dx < 12'(r_w)) && (dy < 12'(r_h));
  assign right  = 14'(r_px) + 14'(r_w);
  assign bottom = 14'(r_py) + 14'(r_h);

  // size clamp for add
  always_comb begin
    if (cur.item.sticker_width == 7'd0) begin
      add_w = WW'(1);
    end else if (DW'(cur.item.sticker_width) > DW'(STICKER_MAX_W)) begin
      add_w = WW'(STICKER_MAX_W);
    end else begin
      add_w = WW'(cur.item.sticker_width);
    end
    if (cur.item.sticker_height == 7'd0) begin
      add_h = HW'(1);
    end else if (EW'(cur.item.sticker_height) > EW'(STICKER_MAX_H)) begin
      add_h = HW'(STICKER_MAX_H);
    end else begin
      add_h = HW'(cur.item.sticker_height);
    end
  end

  // sticker memory addresses
  assign mem_waddr = AW'(SW'(cur.item.slot)) * AW'(STICKER_MAX_W * STICKER_MAX_H)
                   + AW'(YW'(cur.item.pos_y)) * AW'(STICKER_MAX_W)
                   + AW'(XW'(cur.item.pos_x));
  assign mem_raddr = AW'(idx) * AW'(STICKER_MAX_W * STICKER_MAX_H)
                   + AW'(YW'(dy)) * AW'(STICKER_MAX_W)
                   + AW'(XW'(dx));

  slc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pix (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cur.item.pixel_in),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid && !out_valid) state_next = S_RUN;
      S_RUN: begin
        if (finish) state_next = S_IDLE;
        else if (mem_re) state_next = S_WAIT;
      end
      S_WAIT: state_next = finish ? S_IDLE : S_RUN;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    finish   = 1'b0;
    res      = '0;
    tbl_add  = 1'b0;
    tbl_move = 1'b0;
    tbl_rm   = 1'b0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    size_upd = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    unique case (state)
      S_IDLE: q_pop = q_valid && !out_valid;
      S_RUN: begin
        case (cur.kind)
          K_ADD: begin
            if (cnt == limit) begin
              finish     = 1'b1;
              res.status = ST_NOFREE;
            end else if (!r_valid) begin
              tbl_add      = 1'b1;
              finish       = 1'b1;
              res.slot_out = 3'(idx);
            end else begin
              cnt_inc = 1'b1;
            end
          end
          K_WRITE: begin
            finish = 1'b1;
            if (usable && cur.item.pos_x < 12'(r_w) && cur.item.pos_y < 12'(r_h)) begin
              mem_we = 1'b1;
            end else begin
              res.status = ST_BAD;
            end
          end
          K_MOVE: begin
            finish   = 1'b1;
            tbl_move = usable;
            if (!usable) res.status = ST_BAD;
          end
          K_REMOVE: begin
            finish = 1'b1;
            tbl_rm = usable;
            if (!usable) res.status = ST_BAD;
          end
          K_SIZE: begin
            if (cnt == limit) begin
              finish            = 1'b1;
              res.canvas_width  = cw;
              res.canvas_height = ch;
            end else begin
              size_upd = r_valid;
              cnt_inc  = 1'b1;
            end
          end
          K_RENDER: begin
            if (cnt == '0) begin
              finish = 1'b1;
              if (13'(cur.item.pos_x) < base_w && 13'(cur.item.pos_y) < base_h) begin
                res.pixel_out = cur.item.pixel_in;
              end else begin
                res.pixel_out = bg_pixel;
              end
            end else if (r_valid && covers) begin
              mem_re = 1'b1;
            end else begin
              cnt_dec = 1'b1;
            end
          end
          default: begin
            finish     = 1'b1;
            res.status = ST_BAD;
          end
        endcase
      end
      S_WAIT: begin
        if (mem_rdata[7:0] != 8'd0) begin
          finish        = 1'b1;
          res.pixel_out = mem_rdata;
        end else begin
          cnt_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LAYERS; i++) valid[i] <= 1'b0;
    end else begin
      if (clr_en) begin
        for (int i = 0; i < MAX_LAYERS; i++) begin
          if (LW'(i) >= clr_from) valid[i] <= 1'b0;
        end
      end
      if (tbl_add) valid[idx] <= 1'b1;
      if (tbl_rm) valid[idx] <= 1'b0;
    end
  end

  // current word, counter, result and table payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
      cnt <= (q_entry.kind == K_RENDER) ? limit : '0;
      cw  <= 14'(base_w);
      ch  <= 14'(base_h);
    end else begin
      if (cnt_inc) cnt <= LW'(cnt + LW'(1));
      if (cnt_dec) cnt <= LW'(cnt - LW'(1));
      if (size_upd && right > cw) cw <= right;
      if (size_upd && bottom > ch) ch <= bottom;
    end
    if (finish) out_word <= res;
    if (tbl_add) begin
      t_px[idx] <= cur.item.pos_x;
      t_py[idx] <= cur.item.pos_y;
      t_w[idx]  <= add_w;
      t_h[idx]  <= add_h;
    end
    if (tbl_move) begin
      t_px[idx] <= cur.item.pos_x;
      t_py[idx] <= cur.item.pos_y;
    end
    if (tbl_rm) begin
      t_px[idx] <= '0;
      t_py[idx] <= '0;
    end
  end

  // a memory read is always followed by its check cycle
  a_wait_after_read: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> state == S_WAIT)
    else $error("render read not followed by check");

  // a result appears only from a working state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != S_IDLE)
    else $error("result raised from idle");

  // render scan never runs past the slot limit
  a_render_count: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && cur.kind == K_RENDER) |-> cnt <= limit)
    else $error("render scan count beyond limit");

endmodule
`default_nettype wire

// ===== rtl/sprite_layer_compositor_unit.sv =====
// top level: configuration registers, front end and back end
//
// channel | direction | handshake              | payload
// in      | into      | in_valid / in_stall    | in_word  (slc_pkg::in_word_t)
// out     | out of    | out_valid / out_stall  | out_word (slc_pkg::out_word_t)
// cfg     | into      | cfg_we                 | cfg_addr, cfg_data
//
// words are taken one at a time: add and size scan the slot table, one entry
// per cycle; write, move and remove use only their own slot; render scans
// the slots and reads sticker memory once for each covering slot it meets.
// the back end takes its next word in the cycle after the result word has left.
// a two word queue keeps taking input words while a result waits on out_stall, until it is full.
// rst is synchronous; it empties the queue, clears every slot's valid mark
// and loads the register defaults; sticker pixels are not cleared.
`default_nettype none
module sprite_layer_compositor_unit #(
  parameter int MAX_LAYERS    = slc_pkg::MAX_LAYERS_DEF,
  parameter int STICKER_MAX_W = slc_pkg::STICKER_MAX_W_DEF,
  parameter int STICKER_MAX_H = slc_pkg::STICKER_MAX_H_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire slc_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output slc_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [31:0]        cfg_data
);
  import slc_pkg::*;

  localparam int LW = $clog2(MAX_LAYERS + 1);

  logic [3:0]    layers;
  logic [12:0]   base_w, base_h;
  logic [31:0]   bg_pixel;
  logic [LW-1:0] limit, clr_from;
  logic          clr_en;
  logic          q_valid, q_pop;
  q_entry_t      q_entry;

  // effective slot limit
  assign limit    = (32'(layers) < MAX_LAYERS) ? LW'(layers) : LW'(MAX_LAYERS);
  assign clr_from = (32'(cfg_data[3:0]) < MAX_LAYERS) ? LW'(cfg_data[3:0])
                                                      : LW'(MAX_LAYERS);
  assign clr_en   = cfg_we && (cfg_addr == REG_LAYERS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layers   <= 4'd8;
      base_w   <= 13'd4096;
      base_h   <= 13'd4096;
      bg_pixel <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LAYERS: layers   <= cfg_data[3:0];
        REG_BASE_W: base_w   <= cfg_data[12:0];
        REG_BASE_H: base_h   <= cfg_data[12:0];
        REG_BG:     bg_pixel <= cfg_data;
        default: ;
      endcase
    end
  end

  slc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  slc_back #(
    .MAX_LAYERS    (MAX_LAYERS),
    .STICKER_MAX_W (STICKER_MAX_W),
    .STICKER_MAX_H (STICKER_MAX_H),
    .LW            (LW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .limit     (limit),
    .base_w    (base_w),
    .base_h    (base_h),
    .bg_pixel  (bg_pixel),
    .clr_en    (clr_en),
    .clr_from  (clr_from),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
